### rtl/rlm_pkg.sv
// Shared types and constants for the RMS level meter with peak hold.
// Used by rlm_ctrl, rlm_dp and rms_level_meter_peak_hold; depends on nothing.
`timescale 1ns / 1ps

package rlm_pkg;

    // Default buffer length; the top level hands it down as MAX_FRAMES.
    localparam int RLM_MAX_FRAMES = 256;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 7;

    // A square of a 16-bit sample is at most 2^30, so it fits in 31 bits.
    localparam int SQ_W       = 31;
    localparam int FULL_SHIFT = 30;

    // Levels are on a 0..100 scale; squared they compare against sum*10000.
    localparam int LEVEL_MAX = 100;
    localparam int SCALE_MUL = 10000;
    localparam int SCALE_W   = 14;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SQUARE,
        ST_COMPARE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc;
        logic scale;
        logic square;
        logic compare;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic closes;
        logic bit_zero;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/rms_level_meter_peak_hold.sv
// Top level of the RMS level meter with peak hold.
// Instantiates rlm_ctrl and rlm_dp; depends on rlm_pkg.
//
// Each accepted sample is squared and added to the buffer sum. A sample
// marked last, or the one that fills a buffer of MAX_FRAMES, closes the
// buffer. The block then scales the sum, runs the square and compare loop
// of the root search once per level bit (seven bits), and hands the result
// to the output register. No sample is taken during these steps, and the
// hand-off waits while the output register still holds an earlier result.
// The output register lets the next buffer start while a result still
// waits; a second result waits for the first to be taken. The peak clears
// only at reset.
`timescale 1ns / 1ps

module rms_level_meter_peak_hold #(
    parameter int MAX_FRAMES = rlm_pkg::RLM_MAX_FRAMES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rlm_pkg::LEVEL_W-1:0]         o_level,
    output logic [rlm_pkg::LEVEL_W-1:0]         o_peak_level
);
    import rlm_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    rlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and storage.
    rlm_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_peak_level  (o_peak_level)
    );

endmodule

### rtl/rlm_ctrl.sv
// Controller state machine for the RMS level meter.
// Sequences accumulation, scaling, the bit-serial root search and result hand-off.
// Depends on rlm_pkg.
`timescale 1ns / 1ps

module rlm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rlm_pkg::t_dp_sts i_sts,
    output rlm_pkg::t_dp_cmd o_cmd
);
    import rlm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a closing sample starts the level search, which tries one
    // level bit per square and compare pair, then waits for the output slot.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.closes) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE:   n_state = ST_SQUARE;
            ST_SQUARE:  n_state = ST_COMPARE;
            ST_COMPARE: begin
                if (i_sts.bit_zero) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SQUARE;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: samples are taken only in the idle state.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.acc  = i_in_valid;
            end
            ST_SCALE:   o_cmd.scale   = 1'b1;
            ST_SQUARE:  o_cmd.square  = 1'b1;
            ST_COMPARE: o_cmd.compare = 1'b1;
            ST_EMIT:    o_cmd.emit    = i_sts.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/rlm_dp.sv
// Datapath for the RMS level meter: square-and-add accumulator, sample counter,
// bit-serial level search, peak hold and the output register. Depends on rlm_pkg.
`timescale 1ns / 1ps

module rlm_dp #(
    parameter int MAX_FRAMES = rlm_pkg::RLM_MAX_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last_sample,
    input  rlm_pkg::t_dp_cmd              i_cmd,
    output rlm_pkg::t_dp_sts              o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rlm_pkg::LEVEL_W-1:0]   o_level,
    output logic [rlm_pkg::LEVEL_W-1:0]   o_peak_level
);
    import rlm_pkg::*;

    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int SW  = FULL_SHIFT + CW;
    localparam int MW  = SW + SCALE_W;
    localparam int QW  = CW + SCALE_W;
    localparam int LSW = 2 * LEVEL_W;
    localparam int BW  = $clog2(LEVEL_W);

    logic [SW-1:0]      r_sum;
    logic [CW-1:0]      r_cnt;
    logic [QW-1:0]      r_q;
    logic [LEVEL_W-1:0] r_lvl;
    logic [BW-1:0]      r_bit;
    logic [LSW-1:0]     r_sq;
    logic               r_trial_ok;
    logic [LEVEL_W-1:0] r_peak;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level_out;
    logic [LEVEL_W-1:0] r_peak_out;

    logic signed [2*SAMPLE_W-1:0] w_prod;
    logic [SQ_W-1:0]    w_sq;
    logic [MW-1:0]      w_scaled;
    logic [LEVEL_W-1:0] w_trial;
    logic [QW-1:0]      w_need;
    logic               w_keep;
    logic [LEVEL_W-1:0] w_peak_next;

    // Square of the sample; the most negative sample squares to exactly 2^30.
    assign w_prod = i_sample * i_sample;
    assign w_sq   = w_prod[SQ_W-1:0];

    // Sum*10000 / 2^30, floored. Since L*L*N*2^30 is a multiple of 2^30, the
    // test L*L*N*2^30 <= sum*10000 equals L*L*N <= this quotient.
    assign w_scaled = MW'(r_sum) * MW'(SCALE_MUL);

    // Candidate level with the current bit set, and its test against the quotient.
    assign w_trial = r_lvl | (LEVEL_W'(1) << r_bit);
    assign w_need  = QW'(r_sq) * QW'(r_cnt);
    assign w_keep  = r_trial_ok && (w_need <= r_q);

    assign w_peak_next = (r_lvl > r_peak) ? r_lvl : r_peak;

    // Status to the controller.
    assign o_sts.closes   = i_last_sample || (r_cnt == CW'(MAX_FRAMES - 1));
    assign o_sts.bit_zero = (r_bit == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Accumulator and sample counter; cleared once the result is handed off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SW'(w_sq);
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // Bit-serial level search, most significant bit first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
            r_bit <= '0;
        end else if (i_cmd.scale) begin
            r_lvl <= '0;
            r_bit <= BW'(LEVEL_W - 1);
        end else if (i_cmd.compare) begin
            if (w_keep) begin
                r_lvl <= w_trial;
            end
            r_bit <= r_bit - BW'(1);
        end
    end

    // Search operands; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_q <= w_scaled[MW-1:FULL_SHIFT];
        end
        if (i_cmd.square) begin
            r_sq       <= LSW'(w_trial) * LSW'(w_trial);
            r_trial_ok <= (w_trial <= LEVEL_W'(LEVEL_MAX));
        end
    end

    // Peak hold and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_peak      <= w_peak_next;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_level_out <= r_lvl;
            r_peak_out  <= w_peak_next;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_level_out;
    assign o_peak_level = r_peak_out;

    // The search never settles on a level above full scale.
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LEVEL_W'(LEVEL_MAX))
        else $error("level search went above full scale");

    // A result never shows a peak below its own level.
    a_peak_covers_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_peak_out >= r_level_out))
        else $error("peak below reported level");

    // An empty buffer carries no energy.
    a_empty_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_sum == '0))
        else $error("sum not cleared with count");

endmodule

### bench/rms_level_meter_peak_hold_test.sv
// Self-checking testbench for rms_level_meter_peak_hold: drives sample requests
// through a valid/ready driver and checks each level/peak result against an
// in-bench model of the meter. Depends on rlm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module rms_level_meter_peak_hold_test;

    import rlm_pkg::*;

    localparam int FRAMES      = RLM_MAX_FRAMES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_START  = 2000;
    localparam int CALM_END    = 3000;
    localparam int RANDOM_ITEMS = 1420;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lst;
    } t_sample_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak;
    } t_meter_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last_sample = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [LEVEL_W-1:0]         o_level;
    logic [LEVEL_W-1:0]         o_peak_level;

    // Requests waiting to be driven, and results the meter owes us.
    t_sample_req   sample_reqs[$];
    t_meter_result level_results[$];
    t_sample_req   next_req;

    // Model state of the meter.
    logic [39:0]        sq_sum = '0;
    logic [8:0]         frame_count = '0;
    logic [LEVEL_W-1:0] peak_model = '0;

    int cycle_count = 0;
    int queued = 0;
    int samples_taken = 0;
    int buffers_closed = 0;
    int full_closes = 0;
    int results_seen = 0;
    int errors = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    rms_level_meter_peak_hold #(
        .MAX_FRAMES(FRAMES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_last_sample(i_last_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_level      (o_level),
        .o_peak_level (o_peak_level)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Largest level L in 0..100 with L*L*N*2^30 <= sum*10000.
    function automatic logic [LEVEL_W-1:0] rms_level(input logic [39:0] sum,
                                                    input logic [8:0] n);
        longint unsigned lhs;
        longint unsigned unit;
        int best;
        lhs  = 64'(sum) * 64'(SCALE_MUL);
        unit = 64'(n) << FULL_SHIFT;
        best = 0;
        for (int lv = 1; lv <= LEVEL_MAX; lv++) begin
            if (64'(lv * lv) * unit <= lhs) begin
                best = lv;
            end
        end
        return LEVEL_W'(best);
    endfunction

    // Fold one accepted sample into the model; a closed buffer owes a result.
    task automatic meter_accept(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        logic [16:0]   mag;
        t_meter_result res;
        mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        sq_sum      = sq_sum + 40'(mag) * 40'(mag);
        frame_count = frame_count + 9'd1;
        if (lst || frame_count == 9'(FRAMES)) begin
            if (!lst) begin
                full_closes++;
            end
            res.level = rms_level(sq_sum, frame_count);
            if (res.level > peak_model) begin
                peak_model = res.level;
            end
            res.peak = peak_model;
            level_results.push_back(res);
            buffers_closed++;
            sq_sum      = '0;
            frame_count = '0;
        end
    endtask

    task automatic add_sample(input int value, input bit lst);
        t_sample_req req;
        req.smp = value[SAMPLE_W-1:0];
        req.lst = lst;
        sample_reqs.push_back(req);
        queued++;
    endtask

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles at %0t", cycle_count, $realtime);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample driver: offers the next request unless it decides to idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                meter_accept(i_sample, i_last_sample);
                samples_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (sample_reqs.size() != 0 &&
                    ((cycle_count >= CALM_START && cycle_count < CALM_END) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_req = sample_reqs.pop_front();
                    i_in_valid    <= 1'b1;
                    i_sample      <= next_req.smp;
                    i_last_sample <= next_req.lst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result and paces the ready line.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (level_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result level=%0d peak=%0d",
                             $realtime, o_level, o_peak_level);
                end else begin
                    t_meter_result exp_res;
                    exp_res = level_results.pop_front();
                    if (o_level !== exp_res.level) begin
                        errors++;
                        $display("%0t: level expected %0d actual %0d",
                                 $realtime, exp_res.level, o_level);
                    end
                    if (o_peak_level !== exp_res.peak) begin
                        errors++;
                        $display("%0t: peak_level expected %0d actual %0d",
                                 $realtime, exp_res.peak, o_peak_level);
                    end
                end
            end
            // One long hold-off so the result register and the input back up.
            if (!hold_done && results_seen >= 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (cycle_count >= CALM_START && cycle_count < CALM_END) ||
                               ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int len;
        int amp;
        int cap;
        int kind;
        bit lst;
        bit full_open_done;
        bit full_last_done;

        full_open_done = 1'b0;
        full_last_done = 1'b0;

        // Directed buffers, with levels rising slowly so the peak stays live.
        add_sample(0, 1'b1);
        add_sample(1, 1'b1);
        add_sample(-1, 1'b1);
        add_sample(3277, 1'b1);
        // Most negative sample squares to exactly 2^30: level lands on 50.
        add_sample(-32768, 1'b0);
        add_sample(0, 1'b0);
        add_sample(0, 1'b0);
        add_sample(0, 1'b1);
        // Largest positive sample falls just short of that boundary.
        add_sample(32767, 1'b0);
        add_sample(0, 1'b0);
        add_sample(0, 1'b0);
        add_sample(0, 1'b1);
        add_sample(16384, 1'b0);
        add_sample(-16384, 1'b1);
        add_sample(21845, 1'b0);
        add_sample(-21846, 1'b1);

        // Random buffers; the amplitude ceiling grows over the run.
        while (queued < RANDOM_ITEMS) begin
            cap = 2000 + queued * 22;
            if (cap > 32767) begin
                cap = 32767;
            end
            amp = $urandom_range(0, cap);
            if (!full_open_done && queued > 300) begin
                // Buffer runs past the frame limit with last never set: it
                // closes on its own at the limit, the rest starts a new buffer.
                full_open_done = 1'b1;
                for (int k = 0; k < FRAMES + 14; k++) begin
                    add_sample(int'($urandom_range(0, 2 * amp)) - amp,
                               k == FRAMES + 13);
                end
            end else if (!full_last_done && queued > 800) begin
                // Last flag and the frame limit arrive on the same sample.
                full_last_done = 1'b1;
                for (int k = 0; k < FRAMES; k++) begin
                    add_sample(int'($urandom_range(0, 2 * amp)) - amp, k == FRAMES - 1);
                end
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
                for (int k = 0; k < len; k++) begin
                    kind = $urandom_range(0, 15);
                    lst  = (k == len - 1);
                    if (kind == 0 && queued > 700) begin
                        add_sample(int'($urandom_range(0, 65535)) - 32768, lst);
                    end else if (kind == 1 && queued > 1000) begin
                        add_sample(-32768, lst);
                    end else if (kind == 2) begin
                        add_sample(($urandom_range(0, 1) != 0) ? amp : -amp, lst);
                    end else begin
                        add_sample(int'($urandom_range(0, 2 * amp)) - amp, lst);
                    end
                end
            end
        end

        // Full scale reaches the top level; the quiet buffer after it keeps the peak.
        add_sample(-32768, 1'b1);
        add_sample(0, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_taken != queued) begin
            @(posedge i_clk);
        end
        while (level_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d samples in %0d buffers, %0d closed by the %0d-sample limit.",
                 samples_taken, buffers_closed, full_closes, FRAMES);
        $display("Checked %0d results, final peak %0d, %0d mismatches.",
                 results_seen, peak_model, errors);
        if (errors == 0 && level_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
